// ===== hdl/bpep_pkg.sv =====
package bpep_pkg;

    localparam int FIELD_VALUE_W = 16;
    localparam int FIELD_WIDTH_W = 5;
    localparam int BYTE_W        = 8;
    localparam int PARTIAL_W     = 7;
    localparam int PCOUNT_W      = 3;

    localparam logic [BYTE_W-1:0] ESCAPE_BYTE = 8'h03;
    localparam logic [BYTE_W-1:0] ZERO_BYTE   = 8'h00;

    // A zero run saturates at two bytes, which is where escaping kicks in.
    localparam logic [1:0] ZRUN_LIMIT = 2'd2;

    typedef enum logic {
        CMD_EMIT = 1'b0,
        CMD_PAD  = 1'b1
    } t_command;

endpackage

// ===== hdl/bpep_ifs.sv =====
interface bpep_req_if
    import bpep_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [FIELD_VALUE_W-1:0] field_value;
    logic [FIELD_WIDTH_W-1:0] field_width;
    logic                     pad_bit;

    modport source (output valid, output command, output field_value,
                    output field_width, output pad_bit, input ready);
    modport sink   (input valid, input command, input field_value,
                    input field_width, input pad_bit, output ready);
endinterface

interface bpep_res_if
    import bpep_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              is_escape;
    logic              last_of_run;

    modport source (output valid, output out_byte, output is_escape,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input is_escape,
                    input last_of_run, output ready);
endinterface

interface bpep_cfg_if;
    logic valid;
    logic ready;
    logic escape_enable;

    modport source (output valid, output escape_enable, input ready);
    modport sink   (input valid, input escape_enable, output ready);
endinterface

// ===== hdl/bpep_pack.sv =====
module bpep_pack
    import bpep_pkg::*;
#(
    parameter int MAX_FIELD_BITS = 16,
    parameter int NB             = (MAX_FIELD_BITS + 7) / 8,
    parameter int CNW            = $clog2(NB + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bpep_req_if.sink            i_req,
    input  logic                i_job_done,
    output logic                o_job_valid,
    output logic [8*NB-1:0]     o_job_bytes,
    output logic [CNW-1:0]      o_job_count
);

    localparam int AW = MAX_FIELD_BITS + 7;
    localparam int CW = $clog2(MAX_FIELD_BITS + 8);
    localparam int LW = 8 * NB + 8;
    localparam logic [FIELD_WIDTH_W-1:0] MAX_W = FIELD_WIDTH_W'(MAX_FIELD_BITS);

    logic [PARTIAL_W-1:0] r_pbits;
    logic [PCOUNT_W-1:0]  r_pcount;
    logic                 r_job_valid;
    logic [8*NB-1:0]      r_job_bytes;
    logic [CNW-1:0]       r_job_count;

    logic                 accept;
    logic [PCOUNT_W-1:0]  fill;
    logic [CW-1:0]        width;
    logic [AW-1:0]        src;
    logic [AW-1:0]        val_m;
    logic [AW-1:0]        acc;
    logic [CW-1:0]        count;
    logic [LW-1:0]        aligned;
    logic [CNW-1:0]       nbytes;
    logic [8*NB-1:0]      bytes;
    logic [PARTIAL_W-1:0] n_pbits;

    assign i_req.ready = !r_job_valid || i_job_done;
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        fill = PCOUNT_W'(4'd8 - {1'b0, r_pcount});
        if (i_req.command == CMD_PAD) begin
            width = CW'(fill);
            src   = i_req.pad_bit ? {AW{1'b1}} : '0;
        end else begin
            width = (i_req.field_width > MAX_W) ? CW'(MAX_FIELD_BITS)
                                                : CW'(i_req.field_width);
            src   = AW'(i_req.field_value);
        end
        val_m   = src & ~({AW{1'b1}} << width);
        acc     = (AW'(r_pbits) << width) | val_m;
        count   = CW'(r_pcount) + width;
        nbytes  = CNW'(count >> 3);
        // Put the first pending bit at the top so bytes fall out in order.
        aligned = {acc, {(LW-AW){1'b0}}} << (CW'(AW) - count);
        for (int k = 0; k < NB; k++) begin
            bytes[8*k +: 8] = aligned[LW-1-8*k -: 8];
        end
        n_pbits = PARTIAL_W'(acc & ~({AW{1'b1}} << count[2:0]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pbits     <= '0;
            r_pcount    <= '0;
            r_job_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pbits     <= n_pbits;
                r_pcount    <= count[2:0];
                r_job_valid <= (nbytes != '0);
            end else if (i_job_done) begin
                r_job_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job_bytes <= bytes;
            r_job_count <= nbytes;
        end
    end

    assign o_job_valid = r_job_valid;
    assign o_job_bytes = r_job_bytes;
    assign o_job_count = r_job_count;

endmodule

// ===== hdl/bpep_escape.sv =====
module bpep_escape
    import bpep_pkg::*;
#(
    parameter int NB  = 2,
    parameter int CNW = $clog2(NB + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_escape_enable,
    input  logic            i_job_valid,
    input  logic [8*NB-1:0] i_job_bytes,
    input  logic [CNW-1:0]  i_job_count,
    output logic            o_job_done,
    bpep_res_if.source      o_res
);

    localparam int IW = (NB > 1) ? $clog2(NB) : 1;

    logic [IW-1:0]     r_idx;
    logic [1:0]        r_zero_run;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_esc;
    logic              r_out_last;

    logic              load;
    logic              step;
    logic [BYTE_W-1:0] cur;
    logic              insert;
    logic              at_last;
    logic [IW-1:0]     n_idx;
    logic [1:0]        n_zero_run;

    assign load = !r_out_valid || o_res.ready;
    assign step = load && i_job_valid;

    always_comb begin
        cur     = i_job_bytes[8*r_idx +: 8];
        insert  = i_escape_enable && (r_zero_run == ZRUN_LIMIT) && (cur <= ESCAPE_BYTE);
        at_last = (CNW'(r_idx) + CNW'(1)) == i_job_count;
        n_idx      = r_idx;
        n_zero_run = r_zero_run;
        o_job_done = 1'b0;
        if (step) begin
            if (insert) begin
                // The escape clears the run; the index holds, so the held byte goes out after the escape.
                n_zero_run = '0;
            end else begin
                if (cur != ZERO_BYTE) begin
                    n_zero_run = '0;
                end else if (r_zero_run != ZRUN_LIMIT) begin
                    n_zero_run = r_zero_run + 2'd1;
                end
                if (at_last) begin
                    n_idx      = '0;
                    o_job_done = 1'b1;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_zero_run  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx      <= n_idx;
            r_zero_run <= n_zero_run;
            if (load) begin
                r_out_valid <= i_job_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_byte <= insert ? ESCAPE_BYTE : cur;
            r_out_esc  <= insert;
            r_out_last <= !insert && at_last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.out_byte    = r_out_byte;
    assign o_res.is_escape   = r_out_esc;
    assign o_res.last_of_run = r_out_last;

    a_esc_is_03: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_esc |-> r_out_byte == ESCAPE_BYTE && !r_out_last)
        else $error("escape result malformed");

    a_esc_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && insert |-> i_escape_enable)
        else $error("escape inserted while escaping is off");

    a_job_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> i_job_count != '0 && CNW'(r_idx) < i_job_count)
        else $error("byte index outside the pending job");

    a_no_double_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && insert |=> !(step && insert))
        else $error("two escapes in a row");

endmodule

// ===== hdl/bit_packer_with_emulation_prevention.sv =====
// Bit packer with emulation prevention.
//
// Requests arrive on i_req: an emit request appends the low field_width bits of
// field_value (MSB first, width saturated at MAX_FIELD_BITS), a pad request fills
// the partial byte with pad_bit. Every completed byte leaves on o_res, one byte at
// a time, with last_of_run marking the final byte caused by a request.
// When escape_enable is set, a 0x03 byte (is_escape high) is inserted ahead of any
// byte of value 3 or less that follows two zero bytes.
// i_cfg writes escape_enable; it is always ready and should be written only while
// the block is idle.
// A request's bytes pass through the job register and then the output register
// before reaching o_res. Each result byte, data or escape, uses the single-byte
// output port on its own; a new request is accepted once the last byte of the
// pending job moves into the output register, or at once if no job is pending.
// Reset clears the partial byte, the zero-run count and escape_enable; o_res goes
// empty. When o_res stalls, the pending bytes wait in the job and output registers
// and i_req drops ready once the job register is full.
module bit_packer_with_emulation_prevention
    import bpep_pkg::*;
#(
    parameter int MAX_FIELD_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpep_req_if.sink   i_req,
    bpep_cfg_if.sink   i_cfg,
    bpep_res_if.source o_res
);

    // Worst case bytes completed by one request.
    localparam int NB  = (MAX_FIELD_BITS + 7) / 8;
    localparam int CNW = $clog2(NB + 1);

    logic            r_escape_enable;
    logic            job_valid;
    logic [8*NB-1:0] job_bytes;
    logic [CNW-1:0]  job_count;
    logic            job_done;

    // The configuration register is accepted at any time.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_enable <= 1'b0;
        end else if (i_cfg.valid) begin
            r_escape_enable <= i_cfg.escape_enable;
        end
    end

    // Front end: keeps the partial byte and turns each request into a registered job
    // of whole bytes.
    bpep_pack #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS),
        .NB             (NB),
        .CNW            (CNW)
    ) u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_job_done  (job_done),
        .o_job_valid (job_valid),
        .o_job_bytes (job_bytes),
        .o_job_count (job_count)
    );

    // Back end: sends the job bytes one per cycle while o_res is ready, tracking the
    // zero run and inserting escapes.
    bpep_escape #(
        .NB  (NB),
        .CNW (CNW)
    ) u_escape (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_escape_enable (r_escape_enable),
        .i_job_valid     (job_valid),
        .i_job_bytes     (job_bytes),
        .i_job_count     (job_count),
        .o_job_done      (job_done),
        .o_res           (o_res)
    );

endmodule
